// ===== rtl/bba_pkg.sv =====
// Shared constants for the binary buddy allocator.
// Used by the interfaces and the top level; depends on nothing.
`default_nettype none

package bba_pkg;

    // Tree shape: leaves are nodes LEAF_BLOCKS .. 2*LEAF_BLOCKS-1.
    localparam int LEAF_BLOCKS = 64;
    localparam int LEAF_LOG2   = $clog2(LEAF_BLOCKS);
    localparam int NODE_COUNT  = 2 * LEAF_BLOCKS;
    localparam int NODE_AW     = $clog2(NODE_COUNT);
    localparam int DEPTH_W     = $clog2(LEAF_LOG2 + 1);

    // Field widths.
    localparam int ADDR_W   = 48;
    localparam int BYTES_W  = 32;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int LOG2_W   = 5;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 48;

    // Largest effective minimum block exponent.
    localparam logic [LOG2_W-1:0] MAX_MIN_LOG2 = 5'd16;
    localparam logic [LOG2_W-1:0] RESET_MIN_LOG2 = 5'd4;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FIT    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OUTSIDE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_ARENA_BASE     = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MIN_BLOCK_LOG2 = 2'd1;

endpackage

`default_nettype wire

// ===== rtl/bba_if.sv =====
// Valid/ready channel interfaces for the allocator's command and result words.
// Depends on bba_pkg for the field widths.
`default_nettype none

interface bba_in_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::CMD_W-1:0]    command;
    logic [bba_pkg::BYTES_W-1:0]  request_bytes;
    logic [bba_pkg::ADDR_W-1:0]   address;

    modport source (output valid, command, request_bytes, address, input ready);
    modport sink   (input valid, command, request_bytes, address, output ready);
endinterface

interface bba_out_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::ADDR_W-1:0]   address_out;
    logic [bba_pkg::BYTES_W-1:0]  block_bytes;
    logic [bba_pkg::STAT_W-1:0]   status;

    modport source (output valid, address_out, block_bytes, status, input ready);
    modport sink   (input valid, address_out, block_bytes, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/binary_buddy_allocator.sv =====
// Binary buddy allocator over a tree of one-bit node marks kept in a small RAM.
// Depends on bba_pkg, the channel interfaces in bba_if and the RAM bba_ram.
//
// The block takes one command word at a time and answers each with exactly one
// result word. After reset it writes the initial marks into the node RAM and
// accepts no command until that pass ends; configuration writes are taken at
// any time. Every mark read goes through the single read port of the node RAM,
// one read issued per cycle with the data arriving in the following cycle, under
// one sequencer. An allocate first sizes the request, then searches the tree
// depth first, reading each node it visits and stepping back where a subtree
// has no room, then marks the path from the granted node up to the root used.
// A free or query first checks the address, then climbs from the leaf to the
// first used node; a free then releases that node and merges it with each free
// buddy. Results sit in an output register, so the next command is taken while
// a result waits.
`default_nettype none

module binary_buddy_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bba_in_if.sink                             in_ch,
    bba_out_if.source                          out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [bba_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [bba_pkg::CDATA_W-1:0]   cfg_wdata
);

    localparam int AW = bba_pkg::NODE_AW;
    localparam int DW = bba_pkg::DEPTH_W;
    localparam int LW = bba_pkg::LOG2_W;

    // Sequencer states.
    localparam logic [4:0] ST_INIT   = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_SIZE   = 5'd2;
    localparam logic [4:0] ST_DFS_RN = 5'd3;
    localparam logic [4:0] ST_DFS_RL = 5'd4;
    localparam logic [4:0] ST_DFS_RR = 5'd5;
    localparam logic [4:0] ST_DFS_EV = 5'd6;
    localparam logic [4:0] ST_TGT_EV = 5'd7;
    localparam logic [4:0] ST_BACK   = 5'd8;
    localparam logic [4:0] ST_CLR    = 5'd9;
    localparam logic [4:0] ST_CHK1   = 5'd10;
    localparam logic [4:0] ST_CHK2   = 5'd11;
    localparam logic [4:0] ST_CL_RD  = 5'd12;
    localparam logic [4:0] ST_CL_EV  = 5'd13;
    localparam logic [4:0] ST_FR_WR  = 5'd14;
    localparam logic [4:0] ST_FR_EV  = 5'd15;
    localparam logic [4:0] ST_DONE   = 5'd16;

    // Configuration registers.
    logic [bba_pkg::ADDR_W-1:0] arena_base_reg;
    logic [LW-1:0]              min_log2_reg;

    // Sequencer and working registers.
    logic [4:0]                  state_reg, state_next;
    logic [AW-1:0]               init_reg, init_next;
    logic [AW-1:0]               node_reg, node_next;
    logic [DW-1:0]               depth_reg, depth_next;
    logic [DW-1:0]               td_reg, td_next;
    logic [LW-1:0]               wl_reg, wl_next;
    logic [LW-1:0]               e_reg, e_next;
    logic                        mn_reg, mn_next;
    logic                        ml_reg, ml_next;
    logic [bba_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [bba_pkg::BYTES_W-1:0] req_reg, req_next;
    logic [bba_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [bba_pkg::ADDR_W:0]    diff_reg, diff_next;

    // Result being built and the output register.
    logic [bba_pkg::ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [bba_pkg::BYTES_W-1:0] res_bytes_reg, res_bytes_next;
    logic [bba_pkg::STAT_W-1:0]  res_status_reg, res_status_next;
    logic                        out_valid_reg, out_valid_next;
    logic [bba_pkg::ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [bba_pkg::BYTES_W-1:0] out_bytes_reg, out_bytes_next;
    logic [bba_pkg::STAT_W-1:0]  out_status_reg, out_status_next;

    // Node RAM port.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    // Derived values.
    logic                        in_fire;
    logic [LW-1:0]               e_eff;
    logic [LW-1:0]               top_log2;
    logic [AW-1:0]               child_l;
    logic [AW-1:0]               child_r;
    logic [32:0]                 want_pow;
    logic [AW-1:0]               off_mask;
    logic [bba_pkg::ADDR_W-1:0]  alloc_addr;
    logic [bba_pkg::ADDR_W-1:0]  arena_len;
    logic [bba_pkg::ADDR_W-1:0]  leaf_off;
    logic [LW-1:0]               td_full;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign e_eff    = (min_log2_reg > bba_pkg::MAX_MIN_LOG2) ? bba_pkg::MAX_MIN_LOG2
                                                            : min_log2_reg;
    assign top_log2 = e_reg + LW'(bba_pkg::LEAF_LOG2);
    assign child_l  = {node_reg[AW-2:0], 1'b0};
    assign child_r  = {node_reg[AW-2:0], 1'b1};
    assign want_pow = 33'(1) << wl_reg;
    assign td_full  = top_log2 - wl_reg;
    assign off_mask = (AW'(1) << td_reg) - AW'(1);
    assign alloc_addr = arena_base_reg
                      + (bba_pkg::ADDR_W'(node_reg & off_mask) << wl_reg);
    assign arena_len = bba_pkg::ADDR_W'(1) << top_log2;
    assign leaf_off  = diff_reg[bba_pkg::ADDR_W-1:0] >> e_reg;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_base_reg <= '0;
            min_log2_reg   <= bba_pkg::RESET_MIN_LOG2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bba_pkg::REG_ARENA_BASE:
                begin
                    arena_base_reg <= cfg_wdata[bba_pkg::ADDR_W-1:0];
                end
                bba_pkg::REG_MIN_BLOCK_LOG2:
                begin
                    min_log2_reg <= cfg_wdata[LW-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer next-state logic and RAM port control.
    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        node_next       = node_reg;
        depth_next      = depth_reg;
        td_next         = td_reg;
        wl_next         = wl_reg;
        e_next          = e_reg;
        mn_next         = mn_reg;
        ml_next         = ml_reg;
        cmd_next        = cmd_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        diff_next       = diff_reg;
        res_addr_next   = res_addr_reg;
        res_bytes_next  = res_bytes_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = node_reg;
        ram_wdata       = 1'b0;
        ram_raddr       = node_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                // Every mark starts free except the unused node zero.
                ram_we    = 1'b1;
                ram_waddr = init_reg;
                ram_wdata = (init_reg != '0);
                init_next = init_reg + AW'(1);
                if (init_reg == AW'(bba_pkg::NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next        = in_ch.command;
                    req_next        = in_ch.request_bytes;
                    addr_next       = in_ch.address;
                    e_next          = e_eff;
                    wl_next         = e_eff;
                    res_addr_next   = '0;
                    res_bytes_next  = '0;
                    res_status_next = bba_pkg::STAT_OK;
                    if (in_ch.command == bba_pkg::CMD_ALLOC)
                    begin
                        state_next = ST_SIZE;
                    end
                    else if ((in_ch.command == bba_pkg::CMD_FREE ||
                              in_ch.command == bba_pkg::CMD_QUERY) &&
                             in_ch.address != '0)
                    begin
                        state_next = ST_CHK1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SIZE:
            begin
                // Grow the block exponent until it covers the request, or fail if it outgrows the arena.
                if (wl_reg > top_log2)
                begin
                    res_status_next = bba_pkg::STAT_NO_FIT;
                    state_next      = ST_DONE;
                end
                else if (want_pow < {1'b0, req_reg})
                begin
                    wl_next = wl_reg + LW'(1);
                end
                else
                begin
                    td_next    = td_full[DW-1:0];
                    node_next  = AW'(1);
                    depth_next = '0;
                    state_next = ST_DFS_RN;
                end
            end
            ST_DFS_RN:
            begin
                ram_raddr = node_reg;
                state_next = (depth_reg == td_reg) ? ST_TGT_EV : ST_DFS_RL;
            end
            ST_DFS_RL:
            begin
                ram_raddr  = child_l;
                mn_next    = ram_rdata;
                state_next = ST_DFS_RR;
            end
            ST_DFS_RR:
            begin
                ram_raddr  = child_r;
                ml_next    = ram_rdata;
                state_next = ST_DFS_EV;
            end
            ST_DFS_EV:
            begin
                // A used node with both children free is allocated whole.
                if (!mn_reg && ml_reg && ram_rdata)
                begin
                    state_next = ST_BACK;
                end
                else
                begin
                    node_next  = child_l;
                    depth_next = depth_reg + DW'(1);
                    state_next = ST_DFS_RN;
                end
            end
            ST_TGT_EV:
            begin
                if (ram_rdata)
                begin
                    res_addr_next  = alloc_addr;
                    res_bytes_next = want_pow[bba_pkg::BYTES_W-1:0];
                    state_next     = ST_CLR;
                end
                else
                begin
                    state_next = ST_BACK;
                end
            end
            ST_BACK:
            begin
                // Try the right sibling, or climb while coming from the right; at the root the request does not fit.
                if (node_reg == AW'(1))
                begin
                    res_status_next = bba_pkg::STAT_NO_FIT;
                    state_next      = ST_DONE;
                end
                else if (!node_reg[0])
                begin
                    node_next  = node_reg | AW'(1);
                    state_next = ST_DFS_RN;
                end
                else
                begin
                    node_next  = node_reg >> 1;
                    depth_next = depth_reg - DW'(1);
                end
            end
            ST_CLR:
            begin
                // Mark the granted node and its ancestors used.
                ram_we    = 1'b1;
                ram_waddr = node_reg;
                ram_wdata = 1'b0;
                if (node_reg == AW'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    node_next = node_reg >> 1;
                end
            end
            ST_CHK1:
            begin
                diff_next  = {1'b0, addr_reg} - {1'b0, arena_base_reg};
                state_next = ST_CHK2;
            end
            ST_CHK2:
            begin
                if (diff_reg[bba_pkg::ADDR_W] ||
                    diff_reg[bba_pkg::ADDR_W-1:0] >= arena_len)
                begin
                    res_status_next = bba_pkg::STAT_OUTSIDE;
                    state_next      = ST_DONE;
                end
                else
                begin
                    node_next  = {1'b1, leaf_off[bba_pkg::LEAF_LOG2-1:0]};
                    state_next = ST_CL_RD;
                end
            end
            ST_CL_RD:
            begin
                ram_raddr  = node_reg;
                state_next = ST_CL_EV;
            end
            ST_CL_EV:
            begin
                // Climb through free nodes to the first used one; a free root means the address is not allocated.
                if (ram_rdata)
                begin
                    if (node_reg == AW'(1))
                    begin
                        res_status_next = bba_pkg::STAT_NOT_ALLOC;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        node_next  = node_reg >> 1;
                        wl_next    = wl_reg + LW'(1);
                        state_next = ST_CL_RD;
                    end
                end
                else
                begin
                    res_bytes_next = want_pow[bba_pkg::BYTES_W-1:0];
                    state_next = (cmd_reg == bba_pkg::CMD_FREE) ? ST_FR_WR : ST_DONE;
                end
            end
            ST_FR_WR:
            begin
                // Release the node and look at its buddy.
                ram_we    = 1'b1;
                ram_waddr = node_reg;
                ram_wdata = 1'b1;
                ram_raddr = node_reg ^ AW'(1);
                state_next = (node_reg == AW'(1)) ? ST_DONE : ST_FR_EV;
            end
            ST_FR_EV:
            begin
                if (ram_rdata)
                begin
                    node_next  = node_reg >> 1;
                    state_next = ST_FR_WR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loaded when a result is done and the slot is free or being taken.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_addr_next   = out_addr_reg;
        out_bytes_next  = out_bytes_reg;
        out_status_next = out_status_reg;
        if (state_reg == ST_DONE && (!out_valid_reg || out_ch.ready))
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = res_addr_reg;
            out_bytes_next  = res_bytes_reg;
            out_status_next = res_status_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        depth_reg      <= depth_next;
        td_reg         <= td_next;
        wl_reg         <= wl_next;
        e_reg          <= e_next;
        mn_reg         <= mn_next;
        ml_reg         <= ml_next;
        cmd_reg        <= cmd_next;
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        diff_reg       <= diff_next;
        res_addr_reg   <= res_addr_next;
        res_bytes_reg  <= res_bytes_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_bytes_reg  <= out_bytes_next;
        out_status_reg <= out_status_next;
    end

    // Node mark store.
    bba_ram #(
        .WIDTH (1),
        .DEPTH (bba_pkg::NODE_COUNT)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Channel outputs.
    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.address_out = out_addr_reg;
    assign out_ch.block_bytes = out_bytes_reg;
    assign out_ch.status      = out_status_reg;

    // The mark store is never written while waiting for a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !ram_we)
        else $error("mark store written outside a command");

    // The search never goes below the target level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DFS_RN || state_reg == ST_DFS_EV) |-> depth_reg <= td_reg)
        else $error("tree search passed target level");

    // A command is followed by a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ch.ready)
        else $error("second command taken while busy");

    // A granted or sized block is a power of two.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bytes_reg != '0) |-> $onehot(out_bytes_reg))
        else $error("block size not a power of two");

    // The walk never addresses the unused node zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR || state_reg == ST_FR_WR || state_reg == ST_CL_RD)
        |-> node_reg != '0)
        else $error("walk reached node zero");

endmodule

`default_nettype wire

// ===== rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the allocator's node mark store.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
